/* src/hold_and_modify_pixel_encoder_core_assert.svh */
// Assertion macros used by the hold-and-modify encoder core.
`ifndef HOLD_AND_MODIFY_PIXEL_ENCODER_CORE_ASSERT_SVH
`define HOLD_AND_MODIFY_PIXEL_ENCODER_CORE_ASSERT_SVH

// Same-cycle implication, checked only outside reset.
`define HAMENC_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hamenc same-cycle check failed");

// Next-cycle implication, checked only outside reset.
`define HAMENC_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hamenc next-cycle check failed");

`endif

/* src/hamenc_pkg.sv */
// Types, constants and helpers for the hold-and-modify pixel encoder.
`default_nettype none

package hamenc_pkg;

    // Mode register values; the unused code behaves as the cumulative mode.
    localparam logic [1:0] MODE_DELTA   = 2'd0;
    localparam logic [1:0] MODE_PALETTE = 2'd1;
    localparam logic [1:0] MODE_CUMUL   = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_MODE    = 2'd0;
    localparam logic [1:0] CFG_PAL_LO  = 2'd1;
    localparam logic [1:0] CFG_PAL_MID = 2'd2;
    localparam logic [1:0] CFG_PAL_HI  = 2'd3;

    // Reset contents of the palette words (grey ramp).
    localparam logic [59:0] PAL_LO_RST  = 60'd384288398621417745;
    localparam logic [59:0] PAL_MID_RST = 60'd768595566823700070;
    localparam logic [59:0] PAL_HI_RST  = 60'd1152902735025982395;

    // Top two bits of a code: palette index or which channel is modified.
    localparam logic [1:0] OP_PALETTE = 2'b00;
    localparam logic [1:0] OP_BLUE    = 2'b01;
    localparam logic [1:0] OP_RED     = 2'b10;
    localparam logic [1:0] OP_GREEN   = 2'b11;

    // Accumulator saturation bound.
    localparam logic signed [16:0] ACC_LIMIT = 17'sd32767;

    // Programmable entries 1..15, entry 1 at index 0.
    typedef logic [14:0][11:0] palette_t;

    // Held colour and running error sums.
    typedef struct packed {
        logic [3:0]         held_red;
        logic [3:0]         held_green;
        logic [3:0]         held_blue;
        logic signed [15:0] accum_red;
        logic signed [15:0] accum_green;
        logic signed [15:0] accum_blue;
    } state_t;

    // Magnitude of a saturated accumulator; it never exceeds 32767.
    function automatic logic [14:0] acc_mag(input logic signed [15:0] v);
        logic signed [15:0] a;
        begin
            a = v[15] ? -v : v;
            return a[14:0];
        end
    endfunction

endpackage

`default_nettype wire

/* src/hamenc_encode.sv */
// Combinational encode of one pixel against the held colour and palette.
`default_nettype none

module hamenc_encode
(
    input  wire logic [1:0]          mode,
    input  wire hamenc_pkg::palette_t palette,
    input  wire logic [3:0]          red,
    input  wire logic [3:0]          green,
    input  wire logic [3:0]          blue,
    input  wire logic                line_start,
    input  wire hamenc_pkg::state_t  state_cur,
    output logic [5:0]               ham_code,
    output hamenc_pkg::state_t       state_next
);
    import hamenc_pkg::*;

    state_t             base;
    logic [11:0]        colour;
    logic               match;
    logic [3:0]         match_idx;
    logic signed [4:0]  diff_r, diff_g, diff_b;
    logic signed [16:0] sum_r, sum_g, sum_b;
    logic signed [15:0] sat_r, sat_g, sat_b;
    logic [14:0]        mag_r, mag_g, mag_b;
    logic               cumul;
    logic               pick_r, pick_g;

    // A line start clears held colour and accumulators before encoding.
    assign base   = line_start ? '0 : state_cur;
    assign colour = {red, green, blue};
    assign cumul  = mode[1];

    // Palette search; the highest matching index wins, entry 0 is black.
    always_comb
    begin
        match     = (colour == 12'h000);
        match_idx = 4'd0;
        for (int i = 0; i < 15; i++)
        begin
            if (palette[i] == colour)
            begin
                match     = 1'b1;
                match_idx = 4'(i + 1);
            end
        end
        if (mode == MODE_DELTA)
        begin
            match = 1'b0;
        end
    end

    // Per-channel errors of this pixel against the held colour.
    assign diff_r = $signed({1'b0, base.held_red})   - $signed({1'b0, red});
    assign diff_g = $signed({1'b0, base.held_green}) - $signed({1'b0, green});
    assign diff_b = $signed({1'b0, base.held_blue})  - $signed({1'b0, blue});

    // Accumulated errors with symmetric saturation.
    assign sum_r = 17'(base.accum_red)   + 17'(diff_r);
    assign sum_g = 17'(base.accum_green) + 17'(diff_g);
    assign sum_b = 17'(base.accum_blue)  + 17'(diff_b);

    always_comb
    begin
        sat_r = (sum_r > ACC_LIMIT) ? 16'sd32767 :
                (sum_r < -ACC_LIMIT) ? -16'sd32767 : sum_r[15:0];
        sat_g = (sum_g > ACC_LIMIT) ? 16'sd32767 :
                (sum_g < -ACC_LIMIT) ? -16'sd32767 : sum_g[15:0];
        sat_b = (sum_b > ACC_LIMIT) ? 16'sd32767 :
                (sum_b < -ACC_LIMIT) ? -16'sd32767 : sum_b[15:0];
    end

    // Magnitudes used for the channel choice in either delta flavor.
    always_comb
    begin
        if (cumul)
        begin
            mag_r = acc_mag(sat_r);
            mag_g = acc_mag(sat_g);
            mag_b = acc_mag(sat_b);
        end
        else
        begin
            mag_r = 15'(acc_mag(16'(diff_r)));
            mag_g = 15'(acc_mag(16'(diff_g)));
            mag_b = 15'(acc_mag(16'(diff_b)));
        end
    end

    // Largest error wins; ties go to red, then green.
    assign pick_r = (mag_r >= mag_g) && (mag_r >= mag_b);
    assign pick_g = !pick_r && (mag_g >= mag_b);

    // Code and next state.
    always_comb
    begin
        state_next = base;
        if (match)
        begin
            ham_code              = {OP_PALETTE, match_idx};
            state_next.held_red   = red;
            state_next.held_green = green;
            state_next.held_blue  = blue;
        end
        else
        begin
            if (cumul)
            begin
                state_next.accum_red   = sat_r;
                state_next.accum_green = sat_g;
                state_next.accum_blue  = sat_b;
            end
            priority if (pick_r)
            begin
                ham_code                = {OP_RED, red};
                state_next.held_red     = red;
                if (cumul)
                begin
                    state_next.accum_red = '0;
                end
            end
            else if (pick_g)
            begin
                ham_code                = {OP_GREEN, green};
                state_next.held_green   = green;
                if (cumul)
                begin
                    state_next.accum_green = '0;
                end
            end
            else
            begin
                ham_code                = {OP_BLUE, blue};
                state_next.held_blue    = blue;
                if (cumul)
                begin
                    state_next.accum_blue = '0;
                end
            end
        end
    end

endmodule

`default_nettype wire

/* src/hold_and_modify_pixel_encoder_core.sv */
// An accepted pixel is registered in the input stage, then its code in the code stage.
// Throughput: one pixel per cycle while code_stall is low; held colour and accumulators
// loop back through the single encode stage, so each pixel sees the last one's state.
// Reset (rst_n low, asynchronous) empties both stages, clears held colour and
// accumulators, sets mode to delta only and loads the grey-ramp palette.
// Configuration writes are always ready and take effect for the next pixel encoded.
`default_nettype none

module hold_and_modify_pixel_encoder_core
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        pix_valid,
    output logic             pix_stall,
    input  wire logic [7:0]  red,
    input  wire logic [7:0]  green,
    input  wire logic [7:0]  blue,
    input  wire logic        line_start,
    output logic             code_valid,
    input  wire logic        code_stall,
    output logic [5:0]       ham_code,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [59:0] cfg_data
);
    import hamenc_pkg::*;

    `include "hold_and_modify_pixel_encoder_core_assert.svh"

    logic [1:0]  mode_reg;
    logic [59:0] pal_lo_reg, pal_mid_reg, pal_hi_reg;
    state_t      state_reg, state_next;
    logic        in_vld_reg, in_vld_next;
    logic [3:0]  in_red_reg, in_green_reg, in_blue_reg;
    logic        in_ls_reg;
    logic        code_vld_reg, code_vld_next;
    logic [5:0]  code_reg, code_next;
    logic        out_free, advance, accept;
    palette_t    palette;
    logic        adv_delta, adv_keep_acc;
    logic [47:0] accum_all;

    // Handshake control for the two stages.
    assign out_free  = !code_vld_reg || !code_stall;
    assign advance   = in_vld_reg && out_free;
    assign pix_stall = in_vld_reg && !out_free;
    assign accept    = pix_valid && !pix_stall;
    assign cfg_ready = 1'b1;

    assign in_vld_next   = accept ? 1'b1 : (advance ? 1'b0 : in_vld_reg);
    assign code_vld_next = advance ? 1'b1 : (code_stall && code_vld_reg);

    assign code_valid = code_vld_reg;
    assign ham_code   = code_reg;
    assign palette    = {pal_hi_reg, pal_mid_reg, pal_lo_reg};

    // Encode stage.
    hamenc_encode u_encode
    (
        .mode       (mode_reg),
        .palette    (palette),
        .red        (in_red_reg),
        .green      (in_green_reg),
        .blue       (in_blue_reg),
        .line_start (in_ls_reg),
        .state_cur  (state_reg),
        .ham_code   (code_next),
        .state_next (state_next)
    );

    // Control and state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg   <= 1'b0;
            code_vld_reg <= 1'b0;
            state_reg    <= '0;
            mode_reg     <= MODE_DELTA;
            pal_lo_reg   <= PAL_LO_RST;
            pal_mid_reg  <= PAL_MID_RST;
            pal_hi_reg   <= PAL_HI_RST;
        end
        else
        begin
            in_vld_reg   <= in_vld_next;
            code_vld_reg <= code_vld_next;
            if (advance)
            begin
                state_reg <= state_next;
            end
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_MODE:    mode_reg    <= cfg_data[1:0];
                    CFG_PAL_LO:  pal_lo_reg  <= cfg_data;
                    CFG_PAL_MID: pal_mid_reg <= cfg_data;
                    CFG_PAL_HI:  pal_hi_reg  <= cfg_data;
                    default:     mode_reg    <= mode_reg;
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_red_reg   <= red[7:4];
            in_green_reg <= green[7:4];
            in_blue_reg  <= blue[7:4];
            in_ls_reg    <= line_start;
        end
        if (advance)
        begin
            code_reg <= code_next;
        end
    end

    // Terms used by the checks below.
    assign adv_delta    = advance && (mode_reg == MODE_DELTA);
    assign adv_keep_acc = advance && !mode_reg[1] && !in_ls_reg;
    assign accum_all    = {state_reg.accum_red, state_reg.accum_green, state_reg.accum_blue};

    // Checks on the stage control and the encoder's state handling.
    `HAMENC_ASSERT_IMP(a_stall_only_when_full, clk, rst_n, pix_stall, in_vld_reg)
    `HAMENC_ASSERT_NXT(a_advance_loads_code, clk, rst_n, advance, code_vld_reg)
    `HAMENC_ASSERT_NXT(a_delta_mode_no_index, clk, rst_n, adv_delta, (code_reg[5:4] != OP_PALETTE))
    `HAMENC_ASSERT_NXT(a_accum_kept_low_modes, clk, rst_n, adv_keep_acc, $stable(accum_all))

endmodule

`default_nettype wire
